@@ sv/ptc_pkg.sv @@
// Package with the shared types and codes of the port connection table.
`default_nettype none

package ptc_pkg;

    localparam logic [1:0] KIND_REGISTER = 2'd0;
    localparam logic [1:0] KIND_CONNECT  = 2'd1;
    localparam logic [1:0] KIND_TICK     = 2'd2;

    localparam logic [1:0] PTYPE_MIDI = 2'd1;

    localparam int INFO_SINK = 0;
    localparam int INFO_KIND = 1;
    localparam int INFO_W    = 2;

    localparam int FIELD_PORT_W  = 6;
    localparam int FIELD_INDEX_W = 5;
    localparam int FIELD_COUNT_W = 6;
    localparam int TICK_W        = 48;

    typedef enum logic [2:0] {
        STATUS_OK            = 3'd0,
        STATUS_BAD_TYPE      = 3'd1,
        STATUS_PORTS_FULL    = 3'd2,
        STATUS_BAD_PORT      = 3'd3,
        STATUS_DIRECTION     = 3'd4,
        STATUS_TYPE_MISMATCH = 3'd5,
        STATUS_LINKS_FULL    = 3'd6
    } status_t;

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_REG_SCAN  = 7'b0000010,
        S_CHK_SRC   = 7'b0000100,
        S_CHK_DST   = 7'b0001000,
        S_CMP       = 7'b0010000,
        S_LINK_SCAN = 7'b0100000,
        S_APPEND    = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

@@ sv/port_connection_table_top.sv @@
// Top level of the port connection table: sequencer, slot and link stores, results.
//
//  Channel   Handshake           Fields
//  command   start, busy         kind, port_type, port_is_sink, source_port, dest_port
//  result    done (one cycle)    status, new_port_index, link_count, tick_total
//
// A tick item, an item of an unused kind and a register item with a bad type complete straight from the idle state.
// A register item scans the slot valid bits one per cycle until it finds a free slot or reaches the last one.
// A connect item reads both ports from the slot RAM and then walks the stored links through
// the link RAM read port one entry per cycle.
// Reset clears the slot valid bits, the link count and the tick counter; the RAMs are not cleared.
// The result is shown for exactly one cycle on done; the receiver cannot stall it.
`default_nettype none

module port_connection_table_top #(
    parameter int PORT_SLOTS = 32,
    parameter int LINK_SLOTS = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [1:0]                            kind,
    input  wire logic [1:0]                            port_type,
    input  wire logic                                  port_is_sink,
    input  wire logic [ptc_pkg::FIELD_PORT_W-1:0]      source_port,
    input  wire logic [ptc_pkg::FIELD_PORT_W-1:0]      dest_port,
    output logic                                       done,
    output ptc_pkg::status_t                           status,
    output logic      [ptc_pkg::FIELD_INDEX_W-1:0]     new_port_index,
    output logic      [ptc_pkg::FIELD_COUNT_W-1:0]     link_count,
    output logic      [ptc_pkg::TICK_W-1:0]            tick_total
);

    import ptc_pkg::*;

    localparam int PIDX_W  = $clog2(PORT_SLOTS);
    localparam int LIDX_W  = $clog2(LINK_SLOTS);
    localparam int CNT_W   = $clog2(LINK_SLOTS + 1);
    localparam int PEXT_W  = (PIDX_W > FIELD_INDEX_W) ? PIDX_W : FIELD_INDEX_W;
    localparam int CEXT_W  = (CNT_W > FIELD_COUNT_W) ? CNT_W : FIELD_COUNT_W;
    localparam int LINK_W  = 2 * FIELD_PORT_W;

    state_t                     state_reg, state_next;
    logic [PORT_SLOTS-1:0]      slot_used_reg, slot_used_next;
    logic [CNT_W-1:0]           links_reg, links_next;
    logic [TICK_W-1:0]          ticks_reg, ticks_next;
    logic                       done_reg, done_next;

    status_t                    status_reg, status_next;
    logic [FIELD_INDEX_W-1:0]   index_reg, index_next;
    logic [FIELD_PORT_W-1:0]    src_reg, src_next;
    logic [FIELD_PORT_W-1:0]    dst_reg, dst_next;
    logic                       type_reg, type_next;
    logic                       sink_reg, sink_next;
    logic [PIDX_W-1:0]          port_scan_reg, port_scan_next;
    logic [LIDX_W-1:0]          link_scan_reg, link_scan_next;
    logic [INFO_W-1:0]          src_info_reg, src_info_next;

    logic                       slot_we;
    logic [PIDX_W-1:0]          slot_raddr;
    logic [INFO_W-1:0]          slot_rdata;
    logic                       link_we;
    logic [LIDX_W-1:0]          link_raddr;
    logic [LINK_W-1:0]          link_rdata;

    logic                       src_ok;
    logic                       dst_ok;
    logic [PEXT_W-1:0]          port_scan_ext;
    logic [CEXT_W-1:0]          links_ext;
    logic [CNT_W-1:0]           link_scan_plus;

    ptc_ram #(
        .WIDTH (INFO_W),
        .DEPTH (PORT_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (port_scan_reg),
        .wdata ({type_reg, sink_reg}),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    ptc_ram #(
        .WIDTH (LINK_W),
        .DEPTH (LINK_SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (links_reg[LIDX_W-1:0]),
        .wdata ({src_reg, dst_reg}),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    assign src_ok = ({1'b0, src_reg} < 7'(PORT_SLOTS)) && slot_used_reg[src_reg[PIDX_W-1:0]];
    assign dst_ok = ({1'b0, dst_reg} < 7'(PORT_SLOTS)) && slot_used_reg[dst_reg[PIDX_W-1:0]];
    assign port_scan_ext  = PEXT_W'(port_scan_reg);
    assign links_ext      = CEXT_W'(links_reg);
    assign link_scan_plus = CNT_W'(link_scan_reg) + CNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        slot_used_next = slot_used_reg;
        links_next     = links_reg;
        ticks_next     = ticks_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        index_next     = index_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        type_next      = type_reg;
        sink_next      = sink_reg;
        port_scan_next = port_scan_reg;
        link_scan_next = link_scan_reg;
        src_info_next  = src_info_reg;
        slot_we        = 1'b0;
        slot_raddr     = '0;
        link_we        = 1'b0;
        link_raddr     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    src_next       = source_port;
                    dst_next       = dest_port;
                    type_next      = port_type[0];
                    sink_next      = port_is_sink;
                    index_next     = '0;
                    status_next    = STATUS_OK;
                    port_scan_next = '0;
                    case (kind)
                        KIND_REGISTER:
                        begin
                            if (port_type > PTYPE_MIDI)
                            begin
                                status_next = STATUS_BAD_TYPE;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_REG_SCAN;
                            end
                        end
                        KIND_CONNECT:
                        begin
                            state_next = S_CHK_SRC;
                        end
                        KIND_TICK:
                        begin
                            ticks_next = ticks_reg + TICK_W'(1);
                            done_next  = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_REG_SCAN:
            begin
                if (!slot_used_reg[port_scan_reg])
                begin
                    slot_used_next[port_scan_reg] = 1'b1;
                    slot_we     = 1'b1;
                    index_next  = port_scan_ext[FIELD_INDEX_W-1:0];
                    status_next = STATUS_OK;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (port_scan_reg == PIDX_W'(PORT_SLOTS - 1))
                begin
                    status_next = STATUS_PORTS_FULL;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    port_scan_next = port_scan_reg + PIDX_W'(1);
                end
            end
            S_CHK_SRC:
            begin
                if (!src_ok)
                begin
                    status_next = STATUS_BAD_PORT;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    slot_raddr = src_reg[PIDX_W-1:0];
                    state_next = S_CHK_DST;
                end
            end
            S_CHK_DST:
            begin
                src_info_next = slot_rdata;
                if (!dst_ok)
                begin
                    status_next = STATUS_BAD_PORT;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    slot_raddr = dst_reg[PIDX_W-1:0];
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (src_info_reg[INFO_SINK] || !slot_rdata[INFO_SINK])
                begin
                    status_next = STATUS_DIRECTION;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (src_info_reg[INFO_KIND] != slot_rdata[INFO_KIND])
                begin
                    status_next = STATUS_TYPE_MISMATCH;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (links_reg == '0)
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    link_raddr     = '0;
                    link_scan_next = '0;
                    state_next     = S_LINK_SCAN;
                end
            end
            S_LINK_SCAN:
            begin
                if (link_rdata == {src_reg, dst_reg})
                begin
                    status_next = STATUS_OK;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (link_scan_plus == links_reg)
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    link_scan_next = link_scan_reg + LIDX_W'(1);
                    link_raddr     = link_scan_reg + LIDX_W'(1);
                end
            end
            S_APPEND:
            begin
                if (links_reg >= CNT_W'(LINK_SLOTS))
                begin
                    status_next = STATUS_LINKS_FULL;
                end
                else
                begin
                    link_we     = 1'b1;
                    links_next  = links_reg + CNT_W'(1);
                    status_next = STATUS_OK;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slot_used_reg <= '0;
            links_reg     <= '0;
            ticks_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_used_reg <= slot_used_next;
            links_reg     <= links_next;
            ticks_reg     <= ticks_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        index_reg     <= index_next;
        src_reg       <= src_next;
        dst_reg       <= dst_next;
        type_reg      <= type_next;
        sink_reg      <= sink_next;
        port_scan_reg <= port_scan_next;
        link_scan_reg <= link_scan_next;
        src_info_reg  <= src_info_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign new_port_index = index_reg;
    assign link_count     = links_ext[FIELD_COUNT_W-1:0];
    assign tick_total     = ticks_reg;

    // A result is only shown once the sequencer is back in its idle state.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("Result strobe while a transaction is still in progress.");

    // The link count never exceeds the capacity of the link store.
    assert property (@(posedge clk) disable iff (!rst_n) links_reg <= CNT_W'(LINK_SLOTS))
        else $error("Link count above link store capacity.");

    // The link count changes only with a result, and then by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(links_reg) |-> (done_reg && (links_reg == $past(links_reg) + CNT_W'(1))))
        else $error("Link count changed outside of an append.");

    // A tick transaction completes in the next cycle with status ok.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == KIND_TICK)) |=> (done && (status == STATUS_OK)))
        else $error("Tick transaction did not complete in one cycle.");

endmodule

`default_nettype wire

@@ sv/ptc_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module ptc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
